// ----- rtl/core/circular_queue_with_address_search_core_macros.svh -----
// Assertion macros shared by the queue core.
// In synthesis builds every macro expands to nothing.
`ifndef CIRCULAR_QUEUE_WITH_ADDRESS_SEARCH_CORE_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_ADDRESS_SEARCH_CORE_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define CQAS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define CQAS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define CQAS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CQAS_ASSERT(name, clk, rst_n, prop, msg)
`define CQAS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define CQAS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/cqas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cqas_pkg;

  // Field widths of the request and response beats.
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 64;
  localparam int THR_W    = 2;
  localparam int IDX_W    = 5;
  localparam int STAT_W   = 2;
  localparam int CNT_O_W  = 6;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Configuration register indexes.
  localparam logic REG_MATCH_FULL    = 1'b0;
  localparam logic REG_IGNORE_THREAD = 1'b1;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // One stored queue entry.
  typedef struct packed {
    logic [ADDR_W-1:0] line_address;
    logic [ADDR_W-1:0] byte_address;
    logic [THR_W-1:0]  thread_id;
  } slot_t;

endpackage

`default_nettype wire

// ----- rtl/core/cqas_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one operation per beat.
interface cqas_req_if
  import cqas_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] line_address;
  logic [ADDR_W-1:0] byte_address;
  logic [THR_W-1:0]  thread_id;

  modport source (output valid, op, line_address, byte_address, thread_id, input ready);
  modport sink   (input valid, op, line_address, byte_address, thread_id, output ready);
endinterface

// Response channel: one result per beat.
interface cqas_rsp_if
  import cqas_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [IDX_W-1:0]   hit_index;
  logic [STAT_W-1:0]  status;
  logic [CNT_O_W-1:0] count;

  modport source (output valid, hit, hit_index, status, count, input ready);
  modport sink   (input valid, hit, hit_index, status, count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/circular_queue_with_address_search_core.sv -----
// Add, remove and unused op codes: the response beat is registered on acceptance.
// Search: reads one entry per cycle from the single memory read port, head to tail;
// the block takes no new request until the search result is registered, one item at a time.
// Reset (rst_n low, synchronous): clears head, tail, occupancy, config and the controller.
// Entry memory is not cleared; only occupied slots are ever read, so no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "circular_queue_with_address_search_core_macros.svh"

module circular_queue_with_address_search_core
  import cqas_pkg::*;
#(
  parameter int DEPTH       = 32,
  parameter int THREAD_BITS = 2
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cqas_req_if.sink    in_ch,
  cqas_rsp_if.source  out_ch,
  input  wire logic   cfg_we,
  input  wire logic   cfg_index,
  input  wire logic   cfg_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [THR_W-1:0] THR_MASK = THR_W'((1 << THREAD_BITS) - 1);

  // Control state.
  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PTR_W-1:0]   scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0]   scan_n_r, scan_n_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               match_full_r;
  logic               ignore_thr_r;

  // Payload registers.
  logic [PTR_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0]  key_line_r;
  logic [ADDR_W-1:0]  key_byte_r;
  logic [THR_W-1:0]   key_thr_r;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_index_r, hit_index_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [CNT_O_W-1:0] count_r, count_nxt;

  // Entry memory.
  slot_t              mem [DEPTH];
  slot_t              rd_data_r;
  logic               mem_we;
  logic               rd_en;

  logic               accept;
  logic               out_free;
  logic               addr_eq;
  logic               thr_eq;
  logic               found;
  logic               exhausted;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && out_free;
  assign accept       = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit       = hit_r;
  assign out_ch.hit_index = hit_index_r;
  assign out_ch.status    = status_r;
  assign out_ch.count     = count_r;

  // Compare of the entry read in the previous cycle against the search key.
  assign addr_eq   = match_full_r ? (rd_data_r.byte_address == key_byte_r)
                                  : (rd_data_r.line_address == key_line_r);
  assign thr_eq    = ((rd_data_r.thread_id ^ key_thr_r) & THR_MASK) == '0;
  assign found     = rd_pend_r && addr_eq && (thr_eq || ignore_thr_r);
  assign exhausted = !rd_pend_r && (scan_n_r == cnt_r);

  // Next state and outputs.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    scan_ptr_nxt  = scan_ptr_r;
    scan_n_nxt    = scan_n_r;
    rd_pend_nxt   = rd_pend_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    hit_nxt       = hit_r;
    hit_index_nxt = hit_index_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          hit_nxt       = 1'b0;
          hit_index_nxt = '0;
          status_nxt    = STAT_OK;
          count_nxt     = CNT_O_W'(cnt_r);
          out_valid_nxt = 1'b1;
          unique case (in_ch.op)
            OP_SEARCH: begin
              out_valid_nxt = out_valid_r && !out_ch.ready;
              state_nxt     = ST_SCAN;
              scan_ptr_nxt  = head_r;
              scan_n_nxt    = '0;
              rd_pend_nxt   = 1'b0;
            end
            OP_ADD: begin
              if (cnt_r == CNT_FULL) begin
                status_nxt = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                tail_nxt  = ring_next(tail_r);
                cnt_nxt   = cnt_r + CNT_W'(1);
                count_nxt = CNT_O_W'(cnt_r + CNT_W'(1));
              end
            end
            OP_REMOVE: begin
              if (cnt_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                head_nxt  = ring_next(head_r);
                cnt_nxt   = cnt_r - CNT_W'(1);
                count_nxt = CNT_O_W'(cnt_r - CNT_W'(1));
              end
            end
            default: begin
              // Unused code: the beat only reports the occupancy.
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (found || exhausted) begin
          // Hold the scan until the response register can take the result.
          if (out_free) begin
            out_valid_nxt = 1'b1;
            hit_nxt       = found;
            hit_index_nxt = found ? IDX_W'(rd_idx_r) : '0;
            status_nxt    = STAT_OK;
            count_nxt     = CNT_O_W'(cnt_r);
            rd_pend_nxt   = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end else if (scan_n_r != cnt_r) begin
          rd_en        = 1'b1;
          rd_pend_nxt  = 1'b1;
          rd_idx_nxt   = scan_ptr_r;
          scan_ptr_nxt = ring_next(scan_ptr_r);
          scan_n_nxt   = scan_n_r + CNT_W'(1);
        end else begin
          rd_pend_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      cnt_r        <= '0;
      scan_ptr_r   <= '0;
      scan_n_r     <= '0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      match_full_r <= 1'b0;
      ignore_thr_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      scan_n_r    <= scan_n_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MATCH_FULL:    match_full_r <= cfg_data;
          REG_IGNORE_THREAD: ignore_thr_r <= cfg_data;
          default:           ;
        endcase
      end
    end
  end

  // Payload registers and the search key.
  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    hit_r       <= hit_nxt;
    hit_index_r <= hit_index_nxt;
    status_r    <= status_nxt;
    count_r     <= count_nxt;
    if (accept) begin
      key_line_r <= in_ch.line_address;
      key_byte_r <= in_ch.byte_address;
      key_thr_r  <= in_ch.thread_id;
    end
  end

  // Entry memory: one write port at the tail, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= '{line_address: in_ch.line_address,
                       byte_address: in_ch.byte_address,
                       thread_id:    in_ch.thread_id};
    end
    if (rd_en) begin
      rd_data_r <= mem[scan_ptr_r];
    end
  end

  // Checks on the queue bookkeeping and the scan.
  `CQAS_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_FULL, "occupancy above depth")
  `CQAS_ASSERT_IMPL(a_scan_bound, clk, rst_n, state_r == ST_SCAN, scan_n_r <= cnt_r,
                    "scan read more entries than are occupied")
  `CQAS_ASSERT_NEXT(a_scan_frozen, clk, rst_n, state_r == ST_SCAN,
                    $stable(cnt_r) && $stable(head_r) && $stable(tail_r),
                    "queue pointers moved during a search")
  `CQAS_ASSERT_IMPL(a_hit_status, clk, rst_n, out_valid_r && hit_r,
                    status_r == STAT_OK && count_r != '0,
                    "hit reported with bad status or empty queue")

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import cqas_pkg::*;

  localparam int DEPTH           = 32;
  localparam int POOL_SIZE       = 8;
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int LONG_HOLD       = 400;
  localparam int CFG_PAUSE       = 4;
  localparam int END_PAUSE       = DEPTH + 8;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int MAX_REPORTS     = 10;

  // The fourth op code has no function; the block answers it with the occupancy only.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;
  localparam logic [ADDR_W-1:0] PAT_5    = {16{4'h5}};
  localparam logic [ADDR_W-1:0] PAT_A    = {16{4'hA}};

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   hit_index;
    logic [STAT_W-1:0]  status;
    logic [CNT_O_W-1:0] count;
  } q_result_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] line_addr;
    logic [ADDR_W-1:0] byte_addr;
    logic [THR_W-1:0]  thr;
    int                rep;
    bit                known;
    q_result_t         want;
  } q_request_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic cfg_data;

  cqas_req_if req_ch ();
  cqas_rsp_if rsp_ch ();

  circular_queue_with_address_search_core #(
    .DEPTH       (DEPTH),
    .THREAD_BITS (THR_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock: 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow copy of the queue and its configuration.
  logic [ADDR_W-1:0] q_line [DEPTH];
  logic [ADDR_W-1:0] q_byte [DEPTH];
  logic [THR_W-1:0]  q_thr  [DEPTH];
  int                q_head;
  int                q_tail;
  int                q_fill;
  bit                cfg_full_addr;
  bit                cfg_any_thread;

  q_result_t  pending_results[$];
  q_request_t dir_rows[$];
  q_request_t cur_request;

  logic [ADDR_W-1:0] pool_line [POOL_SIZE];
  logic [ADDR_W-1:0] pool_byte [POOL_SIZE];

  int mismatches;
  int hold_req;
  int src_quiet_left;
  int n_beats, n_search, n_hits, n_add, n_drop, n_remove, n_underflow, n_unused;
  int n_cfg_writes;

  // Applies one request to the shadow queue and returns the response it causes.
  function automatic q_result_t queue_response(input logic [OP_W-1:0] op,
                                               input logic [ADDR_W-1:0] la,
                                               input logic [ADDR_W-1:0] ba,
                                               input logic [THR_W-1:0] thr);
    q_result_t r;
    int        p;
    bit        addr_eq;
    r        = '0;
    r.status = STAT_OK;
    case (op)
      OP_SEARCH: begin
        p = q_head;
        for (int n = 0; n < q_fill; n++) begin
          addr_eq = cfg_full_addr ? (q_byte[p] == ba) : (q_line[p] == la);
          if (addr_eq && (cfg_any_thread || q_thr[p] == thr)) begin
            r.hit       = 1'b1;
            r.hit_index = IDX_W'(p);
            break;
          end
          p = (p + 1) % DEPTH;
        end
      end
      OP_ADD: begin
        if (q_fill >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          q_line[q_tail] = la;
          q_byte[q_tail] = ba;
          q_thr[q_tail]  = thr;
          q_tail         = (q_tail + 1) % DEPTH;
          q_fill++;
        end
      end
      OP_REMOVE: begin
        if (q_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          q_head = (q_head + 1) % DEPTH;
          q_fill--;
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_O_W'(q_fill);
    return r;
  endfunction

  // Appends one row to the directed table.
  function automatic void dir_row(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] la,
                                  input logic [ADDR_W-1:0] ba, input logic [THR_W-1:0] thr,
                                  input int rep, input bit known, input logic hit,
                                  input logic [IDX_W-1:0] idx, input logic [STAT_W-1:0] st,
                                  input logic [CNT_O_W-1:0] cnt);
    q_request_t row;
    row.op        = op;
    row.line_addr = la;
    row.byte_addr = ba;
    row.thr       = thr;
    row.rep       = rep;
    row.known     = known;
    row.want      = '{hit: hit, hit_index: idx, status: st, count: cnt};
    dir_rows.push_back(row);
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random request. Searches mostly target live entries so that hits are frequent.
  function automatic q_request_t pick_request(input int add_pct);
    q_request_t rq;
    int         r;
    int         k;
    int         s;
    rq.rep       = 1;
    rq.known     = 1'b0;
    rq.want      = '0;
    rq.thr       = THR_W'($urandom_range(0, 3));
    rq.line_addr = pool_line[$urandom_range(0, POOL_SIZE - 1)];
    rq.byte_addr = pool_byte[$urandom_range(0, POOL_SIZE - 1)];
    if ($urandom_range(0, 9) == 0) begin
      rq.line_addr = {$urandom, $urandom};
      rq.byte_addr = {$urandom, $urandom};
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      rq.op = OP_UNUSED;
    end else if (r < 43) begin
      rq.op = OP_SEARCH;
      if (q_fill > 0 && $urandom_range(0, 99) < 60) begin
        s            = (q_head + $urandom_range(0, q_fill - 1)) % DEPTH;
        rq.line_addr = q_line[s];
        rq.byte_addr = q_byte[s];
        rq.thr       = q_thr[s];
        k            = $urandom_range(0, 9);
        if (k < 2) rq.thr = rq.thr ^ THR_W'(k + 1);
        else if (k == 2) rq.line_addr = {$urandom, $urandom};
        else if (k == 3) rq.byte_addr = {$urandom, $urandom};
      end
    end else if ($urandom_range(0, 99) < add_pct) begin
      rq.op = OP_ADD;
    end else begin
      rq.op = OP_REMOVE;
    end
    return rq;
  endfunction

  // Offers one request beat and returns at the falling edge after it is taken.
  task automatic send_item(input q_request_t rq);
    int gap;
    if (src_quiet_left > 0) begin
      gap = 0;
      src_quiet_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 59) == 0) src_quiet_left = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_request            = rq;
    req_ch.valid          <= 1'b1;
    req_ch.op             <= rq.op;
    req_ch.line_address   <= rq.line_addr;
    req_ch.byte_address   <= rq.byte_addr;
    req_ch.thread_id      <= rq.thr;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    @(negedge clk);
  endtask

  // Lowers valid and waits until every expected response has come back.
  task automatic settle(input int pause);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (pause) @(negedge clk);
  endtask

  // Monitor: mirrors register writes, predicts on each request beat, checks each
  // response beat against the oldest prediction.
  always @(posedge clk) begin
    q_result_t pred;
    q_result_t got;
    q_result_t want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == REG_MATCH_FULL) cfg_full_addr = cfg_data;
        else cfg_any_thread = cfg_data;
      end
      if (req_ch.valid && req_ch.ready) begin
        pred = queue_response(req_ch.op, req_ch.line_address, req_ch.byte_address,
                              req_ch.thread_id);
        pending_results.push_back(cur_request.known ? cur_request.want : pred);
        n_beats++;
        case (req_ch.op)
          OP_SEARCH: begin
            n_search++;
            if (pred.hit) n_hits++;
          end
          OP_ADD: begin
            n_add++;
            if (pred.status == STAT_FULL) n_drop++;
          end
          OP_REMOVE: begin
            n_remove++;
            if (pred.status == STAT_EMPTY) n_underflow++;
          end
          default: n_unused++;
        endcase
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{hit: rsp_ch.hit, hit_index: rsp_ch.hit_index, status: rsp_ch.status,
                count: rsp_ch.count};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] response beat with nothing expected: hit=%0d idx=%0d st=%0d cnt=%0d",
                     $realtime, got.hit, got.hit_index, got.status, got.count);
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit || got.hit_index !== want.hit_index ||
              got.status !== want.status || got.count !== want.count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("[%0t] mismatch: got hit=%0d idx=%0d st=%0d cnt=%0d, want hit=%0d idx=%0d st=%0d cnt=%0d",
                       $realtime, got.hit, got.hit_index, got.status, got.count,
                       want.hit, want.hit_index, want.status, want.count);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    int idle_cycles;
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d responses outstanding",
                 idle_cycles, pending_results.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Response sink: random back-pressure, quiet stretches, and one long hold on request.
  initial begin
    int stall_left;
    int quiet_left;
    int hold_seen;
    int n;
    rsp_ch.ready = 1'b0;
    stall_left   = 0;
    quiet_left   = 0;
    hold_seen    = 0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen  = hold_req;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (quiet_left > 0) begin
        rsp_ch.ready <= 1'b1;
        quiet_left--;
      end else if ($urandom_range(0, 99) < 75) begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 2) quiet_left = $urandom_range(20, 80);
      end else begin
        rsp_ch.ready <= 1'b0;
        n            = pick_gap();
        stall_left   = (n > 0) ? n - 1 : 0;
      end
      @(negedge clk);
    end
  end

  // Main sequence: reset, directed table, then randomized phases per register setting.
  initial begin
    int add_pct;
    bit full_v;
    bit any_v;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_MATCH_FULL;
    cfg_data            = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.op           = OP_SEARCH;
    req_ch.line_address = '0;
    req_ch.byte_address = '0;
    req_ch.thread_id    = '0;
    q_head              = 0;
    q_tail              = 0;
    q_fill              = 0;
    cfg_full_addr       = 1'b0;
    cfg_any_thread      = 1'b0;
    mismatches          = 0;
    hold_req            = 0;
    src_quiet_left      = 0;
    n_beats = 0; n_search = 0; n_hits = 0; n_add = 0; n_drop = 0;
    n_remove = 0; n_underflow = 0; n_unused = 0; n_cfg_writes = 0;

    // Directed rows: op, line, byte, thread, repeat, known?, hit, index, status, count.
    // Search on an empty queue, remove on empty, and the unused op right after reset.
    dir_row(OP_SEARCH, '0, '0, 2'd0, 1, 1, 0, 0, STAT_OK, 0);
    dir_row(OP_REMOVE, '0, '0, 2'd0, 1, 1, 0, 0, STAT_EMPTY, 0);
    dir_row(OP_UNUSED, ALL_ONES, ALL_ONES, 2'd3, 1, 1, 0, 0, STAT_OK, 0);
    // Extreme entries, then hits, a thread miss and the unused op with entries present.
    dir_row(OP_ADD, ALL_ONES, ALL_ONES, 2'd3, 1, 1, 0, 0, STAT_OK, 1);
    dir_row(OP_ADD, '0, '0, 2'd0, 1, 1, 0, 0, STAT_OK, 2);
    dir_row(OP_SEARCH, ALL_ONES, '0, 2'd3, 1, 1, 1, 0, STAT_OK, 2);
    dir_row(OP_SEARCH, '0, ALL_ONES, 2'd0, 1, 1, 1, 1, STAT_OK, 2);
    dir_row(OP_SEARCH, ALL_ONES, ALL_ONES, 2'd0, 1, 1, 0, 0, STAT_OK, 2);
    dir_row(OP_SEARCH, ALL_ONES, PAT_A, 2'd2, 1, 0, 0, 0, STAT_OK, 0);
    dir_row(OP_UNUSED, PAT_5, PAT_A, 2'd1, 1, 0, 0, 0, STAT_OK, 0);
    dir_row(OP_REMOVE, '0, '0, 2'd0, 1, 1, 0, 0, STAT_OK, 1);
    dir_row(OP_SEARCH, ALL_ONES, ALL_ONES, 2'd3, 1, 1, 0, 0, STAT_OK, 1);
    dir_row(OP_SEARCH, '0, '0, 2'd0, 1, 1, 1, 1, STAT_OK, 1);
    // Fill across the ring wrap, then add on a full queue and scan the whole ring.
    dir_row(OP_ADD, PAT_5, PAT_A, 2'd1, DEPTH - 1, 0, 0, 0, STAT_OK, 0);
    dir_row(OP_ADD, PAT_A, PAT_5, 2'd2, 1, 1, 0, 0, STAT_FULL, DEPTH);
    dir_row(OP_SEARCH, PAT_5, '0, 2'd1, 1, 0, 0, 0, STAT_OK, 0);
    dir_row(OP_SEARCH, 64'd1, '0, 2'd2, 1, 0, 0, 0, STAT_OK, 0);
    dir_row(OP_SEARCH, PAT_A, ALL_ONES, 2'd2, 1, 0, 0, 0, STAT_OK, 0);
    // Drain to empty and check the empty cases once more.
    dir_row(OP_REMOVE, '0, '0, 2'd0, DEPTH, 0, 0, 0, STAT_OK, 0);
    dir_row(OP_REMOVE, ALL_ONES, ALL_ONES, 2'd3, 1, 1, 0, 0, STAT_EMPTY, 0);
    dir_row(OP_SEARCH, PAT_5, PAT_A, 2'd1, 1, 1, 0, 0, STAT_OK, 0);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].rep) send_item(dir_rows[i]);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle(CFG_PAUSE);
      case (ph)
        0: begin full_v = 1'b0; any_v = 1'b0; end
        1: begin full_v = 1'b1; any_v = 1'b0; end
        2: begin full_v = 1'b0; any_v = 1'b1; end
        3: begin full_v = 1'b1; any_v = 1'b1; end
        default: begin
          full_v = $urandom_range(0, 1);
          any_v  = $urandom_range(0, 1);
        end
      endcase
      // Register writes while the block is idle.
      cfg_we    <= 1'b1;
      cfg_index <= REG_MATCH_FULL;
      cfg_data  <= full_v;
      @(negedge clk);
      cfg_index <= REG_IGNORE_THREAD;
      cfg_data  <= any_v;
      @(negedge clk);
      cfg_we    <= 1'b0;
      @(negedge clk);
      n_cfg_writes += 2;

      // Small address pool so that line and byte matches diverge between modes.
      for (int k = 0; k < POOL_SIZE; k++) begin
        pool_line[k] = {$urandom, $urandom};
        pool_byte[k] = {$urandom, $urandom};
      end
      pool_line[0] = ph[0] ? ALL_ONES : '0;
      pool_byte[1] = ph[0] ? '0 : ALL_ONES;

      add_pct = 80;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 100 == 0 && i != 0) add_pct = $urandom_range(0, 1) ? 80 : 20;
        if (ph == 2 && i == 60) hold_req <= hold_req + 1;
        send_item(pick_request(add_pct));
      end
    end

    settle(END_PAUSE);
    $display("Run covered %0d request beats: %0d searches (%0d hits), %0d adds (%0d dropped full),",
             n_beats, n_search, n_hits, n_add, n_drop);
    $display("%0d removes (%0d on empty), %0d unused ops, %0d register writes, %0d mismatches.",
             n_remove, n_underflow, n_unused, n_cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
